### sv/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Paged frame allocator package
// Shared widths, command codes, reset constants and the random generator step.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int CmdW       = 2;
  localparam int OwnerW     = 8;
  localparam int PagesW     = 8;
  localparam int LpageW     = 7;
  localparam int FcW        = 8;
  localparam int LfsrW      = 16;

  localparam int MaxFramesDef    = 128;
  localparam int TableEntriesDef = 128;
  localparam int RetryLimitDef   = 1000;

  localparam logic [FcW-1:0]   FrameCountReset = 8'd128;
  localparam logic [LfsrW-1:0] LfsrSeed        = 16'hACE1;

  localparam logic [CmdW-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CmdW-1:0] CMD_DEALLOC = 2'd1;
  localparam logic [CmdW-1:0] CMD_WRITE   = 2'd2;
  localparam logic [CmdW-1:0] CMD_READ    = 2'd3;

  // One step of the Fibonacci generator with taps 16, 14, 13 and 11.
  function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] s);
    logic b;
    b = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {b, s[LfsrW-1:1]};
  endfunction

endpackage
`default_nettype wire

### sv/pfa_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one allocator command.
// ----------------------------------------------------------------------------
interface pfa_in_if
  import pfa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [OwnerW-1:0] owner_id;
  logic [PagesW-1:0] page_count;
  logic [LpageW-1:0] logical_page;

  modport source (output valid, command, owner_id, page_count, logical_page, input ready);
  modport sink (input valid, command, owner_id, page_count, logical_page, output ready);
endinterface
`default_nettype wire

### sv/pfa_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the status and read bit of one command.
// ----------------------------------------------------------------------------
interface pfa_out_if;
  logic valid;
  logic ready;
  logic status;
  logic read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink (input valid, status, read_data, output ready);
endinterface
`default_nettype wire

### sv/pfa_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the frame count register.
// ----------------------------------------------------------------------------
interface pfa_cfg_if
  import pfa_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [FcW-1:0] frame_count;

  modport source (output valid, frame_count, input ready);
  modport sink (input valid, frame_count, output ready);
endinterface
`default_nettype wire

### sv/paged_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Paged frame allocator
// Random free-frame allocator with an owner/frame page table and page content.
// ----------------------------------------------------------------------------
// The block takes one command at a time and returns exactly one result per
// command. The free list, the page table and the page content live in three
// small RAMs. After reset, and after every configuration transfer, a clearing
// pass over max(MAX_FRAMES, TABLE_ENTRIES) addresses (128 at the defaults)
// rebuilds them. The pass keeps the free slots below the frame count valid
// and leaves the generator as it is. No command and no configuration
// transfer is accepted during the pass. Allocation draws random free-list
// slots. Each draw steps the 16-bit generator, reduces it modulo the frame
// count in a bit-serial remainder unit and checks the slot that was read. A
// page gives up after RETRY_LIMIT failed draws. A failed allocation hands
// back every frame it took, reading each back from the page table and
// writing it to the next empty free-list slot. Deallocate walks the whole
// page table, and write and read walk it until they find their page, each
// entry waiting on the registered table read. A frame that is returned goes
// to the next empty free-list slot, and a read that finds its page fetches
// the content bit in an extra state. The configuration register may only
// be written while no command is in flight. A finished result waits in an
// output register, and a new command is taken as soon as the sequencer is
// back in idle.
module paged_frame_allocator
  import pfa_pkg::*;
#(
  parameter int MAX_FRAMES    = MaxFramesDef,
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int RETRY_LIMIT   = RetryLimitDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pfa_in_if.sink    in_i,
  pfa_out_if.source out_o,
  pfa_cfg_if.sink   cfg_i
);
  localparam int FW   = $clog2(MAX_FRAMES);
  localparam int NW   = $clog2(MAX_FRAMES + 1);
  localparam int IW   = $clog2(TABLE_ENTRIES);
  localparam int TW   = $clog2(TABLE_ENTRIES + 1);
  localparam int RW   = (RETRY_LIMIT > 1) ? $clog2(RETRY_LIMIT) : 1;
  localparam int ClrN = (MAX_FRAMES > TABLE_ENTRIES) ? MAX_FRAMES : TABLE_ENTRIES;
  localparam int CW   = $clog2(ClrN);
  localparam int TblW = 1 + OwnerW + FW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DRAW    = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_CHK     = 4'd3;
  localparam logic [3:0] S_RB_RD   = 4'd4;
  localparam logic [3:0] S_RB_WAIT = 4'd5;
  localparam logic [3:0] S_RET     = 4'd6;
  localparam logic [3:0] S_RET_W   = 4'd7;
  localparam logic [3:0] S_SCAN    = 4'd8;
  localparam logic [3:0] S_SCAN_W  = 4'd9;
  localparam logic [3:0] S_RDATA   = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;
  localparam logic [3:0] S_CLR     = 4'd12;

  // Active frame count: zero acts as one, large values clip to the maximum.
  function automatic logic [NW-1:0] n_of(input logic [FcW-1:0] v);
    if (v == '0) begin
      return NW'(1);
    end else if (int'(v) > MAX_FRAMES) begin
      return NW'(MAX_FRAMES);
    end
    return NW'(v);
  endfunction

  logic [3:0]              state_q, state_d;
  logic [CmdW-1:0]         cmd_q, cmd_d;
  logic [OwnerW-1:0]       owner_q, owner_d;
  logic [LpageW-1:0]       lpage_q, lpage_d;
  logic [TW-1:0]           pages_q, pages_d;
  logic [TW-1:0]           fill_q, fill_d;
  logic [TW-1:0]           p_q, p_d;
  logic [TW-1:0]           k_q, k_d;
  logic [TW-1:0]           i_q, i_d;
  logic [TW-1:0]           cnt_q, cnt_d;
  logic [NW-1:0]           j_q, j_d;
  logic [RW-1:0]           tries_q, tries_d;
  logic [FW-1:0]           frame_q, frame_d;
  logic [LfsrW-1:0]        lfsr_q, lfsr_d;
  logic [FcW-1:0]          fc_q, fc_d;
  logic [CW-1:0]           clr_q, clr_d;
  logic                    res_status_q, res_status_d;
  logic                    res_data_q, res_data_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_status_q, out_status_d;
  logic                    out_data_q, out_data_d;

  logic [NW-1:0]           n_cur;
  logic                    in_xfer, out_xfer, cfg_xfer;
  logic                    div_start, div_done;
  logic [NW-1:0]           div_rem;
  logic [FW-1:0]           rem_slot;
  logic                    free_we;
  logic [FW-1:0]           free_waddr, free_raddr;
  logic [FW:0]             free_wdata, free_rdata;
  logic                    tbl_we;
  logic [IW-1:0]           tbl_waddr, tbl_raddr;
  logic [TblW-1:0]         tbl_wdata, tbl_rdata;
  logic [FW-1:0]           tbl_frame;
  logic                    cont_we;
  logic [FW-1:0]           cont_waddr;
  logic                    cont_wdata, cont_rdata;
  logic                    hit;
  logic [3:0]              ret_state;

  assign n_cur    = n_of(fc_q);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign cfg_xfer = cfg_i.valid && cfg_i.ready;

  // A configuration transfer wins over a command offered in the same cycle.
  assign in_i.ready      = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_i.ready     = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.read_data = out_data_q;

  assign rem_slot   = div_rem[FW-1:0];
  assign free_raddr = (state_q == S_RET) ? j_q[FW-1:0] : rem_slot;
  assign tbl_frame  = tbl_rdata[FW-1:0];
  assign tbl_raddr  = (state_q == S_RB_RD) ? IW'(fill_q + k_q) : i_q[IW-1:0];
  assign hit        = tbl_rdata[TblW-1] &&
                      (tbl_rdata[OwnerW+FW-1:FW] == owner_q);
  assign ret_state  = (cmd_q == CMD_ALLOC) ? S_RB_RD : S_SCAN;

  pfa_rem #(
    .DivW(NW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lfsr_d),
    .divisor_i  (n_cur),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Free list: a valid bit and a frame number per slot.
  pfa_ram #(
    .Width(FW + 1),
    .Depth(MAX_FRAMES)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  // Page table: a valid bit, the owner and the frame per entry.
  pfa_ram #(
    .Width(TblW),
    .Depth(TABLE_ENTRIES)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Page content: one bit per frame, addressed by the frame of the table read.
  pfa_ram #(
    .Width(1),
    .Depth(MAX_FRAMES)
  ) u_cont_ram (
    .clk_i   (clk_i),
    .we_i    (cont_we),
    .waddr_i (cont_waddr),
    .wdata_i (cont_wdata),
    .raddr_i (tbl_frame),
    .rdata_o (cont_rdata)
  );

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    owner_d       = owner_q;
    lpage_d       = lpage_q;
    pages_d       = pages_q;
    fill_d        = fill_q;
    p_d           = p_q;
    k_d           = k_q;
    i_d           = i_q;
    cnt_d         = cnt_q;
    j_d           = j_q;
    tries_d       = tries_q;
    frame_d       = frame_q;
    lfsr_d        = lfsr_q;
    fc_d          = fc_q;
    clr_d         = clr_q;
    res_status_d  = res_status_q;
    res_data_d    = res_data_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_data_d    = out_data_q;
    div_start     = 1'b0;
    free_we       = 1'b0;
    free_waddr    = '0;
    free_wdata    = '0;
    tbl_we        = 1'b0;
    tbl_waddr     = '0;
    tbl_wdata     = '0;
    cont_we       = 1'b0;
    cont_waddr    = '0;
    cont_wdata    = 1'b0;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        // Slot i holds frame i and is free below the frame count.
        if (int'(clr_q) < MAX_FRAMES) begin
          free_we    = 1'b1;
          free_waddr = clr_q[FW-1:0];
          free_wdata = {int'(clr_q) < int'(n_cur), clr_q[FW-1:0]};
          cont_we    = 1'b1;
          cont_waddr = clr_q[FW-1:0];
          cont_wdata = 1'b0;
        end
        if (int'(clr_q) < TABLE_ENTRIES) begin
          tbl_we    = 1'b1;
          tbl_waddr = clr_q[IW-1:0];
          tbl_wdata = '0;
        end
        if (clr_q == CW'(ClrN - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + CW'(1);
        end
      end
      S_IDLE: begin
        if (cfg_xfer) begin
          fc_d    = cfg_i.frame_count;
          fill_d  = '0;
          clr_d   = '0;
          state_d = S_CLR;
        end else if (in_xfer) begin
          cmd_d   = in_i.command;
          owner_d = in_i.owner_id;
          lpage_d = in_i.logical_page;
          i_d     = '0;
          j_d     = '0;
          cnt_d   = '0;
          case (in_i.command)
            CMD_ALLOC: begin
              res_data_d = 1'b0;
              if (int'(fill_q) + int'(in_i.page_count) > TABLE_ENTRIES) begin
                res_status_d = 1'b1;
                state_d      = S_DONE;
              end else if (in_i.page_count == '0) begin
                res_status_d = 1'b0;
                state_d      = S_DONE;
              end else begin
                pages_d = TW'(in_i.page_count);
                p_d     = '0;
                tries_d = '0;
                state_d = S_DRAW;
              end
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_DRAW: begin
        lfsr_d    = lfsr_next(lfsr_q);
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        // The drawn slot is read from the free list in the cycle of the result.
        if (div_done) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (free_rdata[FW]) begin
          free_we    = 1'b1;
          free_waddr = rem_slot;
          free_wdata = {1'b0, free_rdata[FW-1:0]};
          tbl_we     = 1'b1;
          tbl_waddr  = IW'(fill_q + p_q);
          tbl_wdata  = {1'b1, owner_q, free_rdata[FW-1:0]};
          p_d        = p_q + TW'(1);
          if (p_q + TW'(1) == pages_q) begin
            fill_d       = fill_q + pages_q;
            res_status_d = 1'b0;
            res_data_d   = 1'b0;
            state_d      = S_DONE;
          end else begin
            tries_d = '0;
            state_d = S_DRAW;
          end
        end else if (tries_q == RW'(RETRY_LIMIT - 1)) begin
          k_d     = '0;
          j_d     = '0;
          state_d = S_RB_RD;
        end else begin
          tries_d = tries_q + RW'(1);
          state_d = S_DRAW;
        end
      end
      S_RB_RD: begin
        if (k_q == p_q) begin
          res_status_d = 1'b1;
          res_data_d   = 1'b0;
          state_d      = S_DONE;
        end else begin
          state_d = S_RB_WAIT;
        end
      end
      S_RB_WAIT: begin
        frame_d   = tbl_frame;
        tbl_we    = 1'b1;
        tbl_waddr = IW'(fill_q + k_q);
        tbl_wdata = '0;
        k_d       = k_q + TW'(1);
        state_d   = S_RET;
      end
      S_RET: begin
        // First empty slot below the frame count; later returns resume after it.
        if (j_q >= n_cur) begin
          state_d = ret_state;
        end else begin
          state_d = S_RET_W;
        end
      end
      S_RET_W: begin
        j_d = j_q + NW'(1);
        if (!free_rdata[FW]) begin
          free_we    = 1'b1;
          free_waddr = j_q[FW-1:0];
          free_wdata = {1'b1, frame_q};
          state_d    = ret_state;
        end else begin
          state_d = S_RET;
        end
      end
      S_SCAN: begin
        if (i_q == TW'(TABLE_ENTRIES)) begin
          res_status_d = (cmd_q != CMD_DEALLOC);
          res_data_d   = 1'b0;
          state_d      = S_DONE;
        end else begin
          state_d = S_SCAN_W;
        end
      end
      S_SCAN_W: begin
        i_d     = i_q + TW'(1);
        state_d = S_SCAN;
        if (hit) begin
          if (cmd_q == CMD_DEALLOC) begin
            tbl_we    = 1'b1;
            tbl_waddr = i_q[IW-1:0];
            tbl_wdata = '0;
            frame_d   = tbl_frame;
            state_d   = S_RET;
          end else if (int'(cnt_q) == int'(lpage_q)) begin
            res_status_d = 1'b0;
            res_data_d   = 1'b0;
            if (cmd_q == CMD_WRITE) begin
              cont_we    = 1'b1;
              cont_waddr = tbl_frame;
              cont_wdata = 1'b1;
              state_d    = S_DONE;
            end else begin
              state_d = S_RDATA;
            end
          end else begin
            cnt_d = cnt_q + TW'(1);
          end
        end
      end
      S_RDATA: begin
        res_data_d = cont_rdata;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      fill_q      <= '0;
      lfsr_q      <= LfsrSeed;
      fc_q        <= FrameCountReset;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_ALLOC;
      p_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      tries_q     <= '0;
      pages_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fill_q      <= fill_d;
      lfsr_q      <= lfsr_d;
      fc_q        <= fc_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      p_q         <= p_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      tries_q     <= tries_d;
      pages_q     <= pages_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q      <= owner_d;
    lpage_q      <= lpage_d;
    frame_q      <= frame_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= TABLE_ENTRIES)
    else $error("page table fill beyond its size");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("remainder result outside the draw wait");

  a_take_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> int'(fill_q) + int'(p_q) < TABLE_ENTRIES)
    else $error("taking a frame beyond the page table");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("command accepted without leaving idle");

  a_ret_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RET_W |-> j_q < n_cur)
    else $error("frame returned beyond the frame count");

endmodule
`default_nettype wire

### sv/pfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### sv/pfa_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division of the random word by the frame count, one bit a cycle.
// ----------------------------------------------------------------------------
module pfa_rem
  import pfa_pkg::*;
#(
  parameter int DivW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [LfsrW-1:0] dividend_i,
  input  wire logic [DivW-1:0]  divisor_i,
  output logic                  done_o,
  output logic      [DivW-1:0]  rem_o
);
  localparam int CntW = $clog2(LfsrW + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [LfsrW-1:0] quo_q, quo_d;
  logic [DivW:0]    trial;

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[LfsrW-1]};
    if (start_i) begin
      cnt_d = CntW'(LfsrW);
      rem_d = '0;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DivW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = DivW'(trial);
      end
      quo_d  = {quo_q[LfsrW-2:0], 1'b0};
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### tb/sv/tb_paged_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged frame allocator testbench
// Drives allocate, deallocate, write and read commands through the valid/ready
// channels under several frame counts and idle patterns. A self-contained
// model of the free list, page table, page content and draw generator predicts
// each status and read bit, and a scoreboard checks every result in order.
// ----------------------------------------------------------------------------
module tb_paged_frame_allocator;
  import pfa_pkg::*;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;
  localparam int   FRAMES     = MaxFramesDef;
  localparam int   ENTRIES    = TableEntriesDef;
  localparam int   RETRIES    = RetryLimitDef;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [OwnerW-1:0] owner_id;
    logic [PagesW-1:0] page_count;
    logic [LpageW-1:0] logical_page;
  } command_t;

  typedef struct packed {
    logic status;
    logic read_data;
  } outcome_t;

  // Scoreboard: keeps its own copy of the allocator state, computes the
  // outcome of every accepted command and checks results in order.
  class alloc_scoreboard;
    logic [FcW-1:0]    frame_cnt;
    logic [6:0]        slot_frame[FRAMES];
    bit                slot_free[FRAMES];
    logic [8:0]        owner_tag[ENTRIES];
    logic [6:0]        page_frame[ENTRIES];
    int                fill;
    bit                content[FRAMES];
    logic [LfsrW-1:0]  draw_state;
    outcome_t          pending[$];
    int                errors;

    function new();
      draw_state = LfsrSeed;
      errors     = 0;
      configure(FrameCountReset);
    endfunction

    function int frames_in_use_range();
      if (frame_cnt == 0) return 1;
      if (frame_cnt > FRAMES) return FRAMES;
      return frame_cnt;
    endfunction

    function void configure(logic [FcW-1:0] value);
      int n;
      frame_cnt = value;
      n = frames_in_use_range();
      for (int i = 0; i < FRAMES; i++) begin
        slot_frame[i] = i[6:0];
        slot_free[i]  = (i < n);
        content[i]    = 1'b0;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        owner_tag[i]  = '0;
        page_frame[i] = '0;
      end
      fill = 0;
    endfunction

    function int free_frames();
      int c;
      c = 0;
      for (int i = 0; i < frames_in_use_range(); i++) c += slot_free[i];
      return c;
    endfunction

    function int owner_pages(logic [OwnerW-1:0] owner);
      int c;
      c = 0;
      for (int i = 0; i < ENTRIES; i++) c += (owner_tag[i] == {1'b1, owner});
      return c;
    endfunction

    // Hands a frame back to the first empty slot of the active range.
    function void give_back(logic [6:0] frame);
      for (int j = 0; j < frames_in_use_range(); j++) begin
        if (!slot_free[j]) begin
          slot_frame[j] = frame;
          slot_free[j]  = 1'b1;
          return;
        end
      end
    endfunction

    function logic draw_bit_step();
      logic b;
      b = draw_state[0] ^ draw_state[2] ^ draw_state[3] ^ draw_state[5];
      draw_state = {b, draw_state[LfsrW-1:1]};
      return b;
    endfunction

    function logic allocate_pages(logic [OwnerW-1:0] owner, int pages);
      logic [6:0] taken[ENTRIES];
      int  n, slot;
      bit  got;
      logic unused;
      n = frames_in_use_range();
      if (fill + pages > ENTRIES) return STATUS_ERR;
      for (int p = 0; p < pages; p++) begin
        got = 1'b0;
        for (int t = 0; t < RETRIES && !got; t++) begin
          unused = draw_bit_step();
          slot = int'(draw_state) % n;
          if (slot_free[slot]) begin
            taken[p]        = slot_frame[slot];
            slot_free[slot] = 1'b0;
            got             = 1'b1;
          end
        end
        if (!got) begin
          for (int k = 0; k < p; k++) give_back(taken[k]);
          return STATUS_ERR;
        end
      end
      for (int p = 0; p < pages; p++) begin
        owner_tag[fill + p]  = {1'b1, owner};
        page_frame[fill + p] = taken[p];
      end
      fill += pages;
      return STATUS_OK;
    endfunction

    function outcome_t predict_outcome(command_t c);
      outcome_t o;
      int count, hit;
      o = '{status: STATUS_OK, read_data: 1'b0};
      case (c.command)
        CMD_ALLOC: begin
          o.status = allocate_pages(c.owner_id, int'(c.page_count));
        end
        CMD_DEALLOC: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (owner_tag[i] == {1'b1, c.owner_id}) begin
              give_back(page_frame[i]);
              owner_tag[i]  = '0;
              page_frame[i] = '0;
            end
          end
        end
        default: begin
          count = 0;
          hit   = -1;
          for (int i = 0; i < ENTRIES && hit < 0; i++) begin
            if (owner_tag[i] == {1'b1, c.owner_id}) begin
              if (count == int'(c.logical_page)) hit = i;
              count++;
            end
          end
          if (hit < 0) o.status = STATUS_ERR;
          else if (c.command == CMD_WRITE) content[page_frame[hit]] = 1'b1;
          else o.read_data = content[page_frame[hit]];
        end
      endcase
      return o;
    endfunction

    function void note_command(command_t c);
      pending.push_back(predict_outcome(c));
    endfunction

    task report(string msg);
      $display("%t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic status, logic read_data);
      outcome_t want;
      if (pending.size() == 0) begin
        report("result with no command outstanding");
        return;
      end
      want = pending.pop_front();
      if (status !== want.status)
        report($sformatf("status got %b want %b", status, want.status));
      if (read_data !== want.read_data)
        report($sformatf("read_data got %b want %b", read_data, want.read_data));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pfa_in_if  cmd_if ();
  pfa_out_if res_if ();
  pfa_cfg_if cfg_if ();

  paged_frame_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  alloc_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  // Allocations that cannot find a frame retry a thousand times, which is
  // slow, so only a handful are provoked on purpose.
  int slow_failures_left = 8;

  initial begin
    cmd_if.valid        = 1'b0;
    cmd_if.command      = CMD_ALLOC;
    cmd_if.owner_id     = '0;
    cmd_if.page_count   = '0;
    cmd_if.logical_page = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.frame_count  = FrameCountReset;
    res_if.ready        = 1'b0;
  end

  // Result side: check every transfer and stall at random according to the
  // current phase.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) sb.check_result(res_if.status, res_if.read_data);
      res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Sends one command; the transfer is noted in the scoreboard at the edge
  // where it happens, so the next command is built from the updated state.
  task send_command(command_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= c.command;
    cmd_if.owner_id     <= c.owner_id;
    cmd_if.page_count   <= c.page_count;
    cmd_if.logical_page <= c.logical_page;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(c);
  endtask

  task wait_drained();
    cmd_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // The register may only change while no command is in flight.
  task write_frame_count(logic [FcW-1:0] value);
    wait_drained();
    cfg_if.valid       <= 1'b1;
    cfg_if.frame_count <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.configure(value);
  endtask

  function command_t make_cmd(logic [CmdW-1:0] cmd, logic [OwnerW-1:0] owner,
                              logic [PagesW-1:0] pages, logic [LpageW-1:0] lpage);
    return '{command: cmd, owner_id: owner, page_count: pages, logical_page: lpage};
  endfunction

  // Random command, mostly well formed: owners from a small pool so that
  // pages pile up, page counts the free list can satisfy, and page indexes
  // that exist, with some noise of every kind mixed in.
  function command_t random_command();
    command_t c;
    int r, free_n, have, room;
    r = $urandom_range(99);
    c.owner_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    c.page_count   = '0;
    c.logical_page = 7'($urandom);
    have = sb.owner_pages(c.owner_id);
    if (r < 38) begin
      c.command = CMD_ALLOC;
      free_n = sb.free_frames();
      room   = ENTRIES - sb.fill;
      r = $urandom_range(99);
      if (r < 5) begin
        c.page_count = 8'($urandom_range(ENTRIES));
        if (c.page_count <= room && c.page_count > free_n) c.page_count = 8'(room + 1);
        if (c.page_count > ENTRIES) c.page_count = 8'(ENTRIES);
        if (c.page_count <= room) c.page_count = 8'(free_n < room ? free_n : room);
      end else if (r < 7 && slow_failures_left > 0 && free_n < room) begin
        slow_failures_left--;
        c.page_count = 8'(free_n + 1);
      end else begin
        c.page_count = 8'($urandom_range(free_n < 4 ? free_n : 4));
        if (c.page_count > room) c.page_count = 8'(room);
      end
    end else if (r < 50) begin
      c.command = CMD_DEALLOC;
    end else begin
      c.command = (r < 75) ? CMD_WRITE : CMD_READ;
      if (have > 0 && $urandom_range(4) != 0) c.logical_page = 7'($urandom_range(have - 1));
    end
    if ($urandom_range(19) == 0) c.page_count = 8'($urandom_range(255));
    if (c.command == CMD_ALLOC) c.page_count = c.page_count > ENTRIES ? 8'(ENTRIES) : c.page_count;
    return c;
  endfunction

  initial begin
    logic [FcW-1:0] settings[$];
    int idle_mode[4][2];
    idle_mode = '{'{0, 0}, '{57, 0}, '{0, 57}, '{33, 33}};
    settings  = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd200, 8'd2, 8'd127, 8'd16};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset frame count.
    send_command(make_cmd(CMD_ALLOC, 8'd0, 8'd0, 7'd0));
    send_command(make_cmd(CMD_WRITE, 8'd0, 8'd0, 7'd0));
    send_command(make_cmd(CMD_ALLOC, 8'd255, 8'd3, 7'd0));
    send_command(make_cmd(CMD_WRITE, 8'd255, 8'd0, 7'd1));
    send_command(make_cmd(CMD_READ, 8'd255, 8'd0, 7'd1));
    send_command(make_cmd(CMD_READ, 8'd255, 8'd0, 7'd0));
    send_command(make_cmd(CMD_READ, 8'd255, 8'd0, 7'd127));
    send_command(make_cmd(CMD_ALLOC, 8'd1, 8'd128, 7'd0));
    send_command(make_cmd(CMD_DEALLOC, 8'd7, 8'd0, 7'd0));
    send_command(make_cmd(CMD_DEALLOC, 8'd255, 8'd0, 7'd0));
    send_command(make_cmd(CMD_READ, 8'd255, 8'd0, 7'd0));
    // A single frame: the second owner finds no free frame at all.
    write_frame_count(8'd1);
    send_command(make_cmd(CMD_ALLOC, 8'd5, 8'd1, 7'd0));
    send_command(make_cmd(CMD_ALLOC, 8'd6, 8'd1, 7'd0));
    send_command(make_cmd(CMD_WRITE, 8'd5, 8'd0, 7'd0));
    send_command(make_cmd(CMD_READ, 8'd5, 8'd0, 7'd0));
    send_command(make_cmd(CMD_DEALLOC, 8'd5, 8'd0, 7'd0));
    send_command(make_cmd(CMD_ALLOC, 8'd6, 8'd1, 7'd0));
    // Full table in one allocation, then the table-full error.
    write_frame_count(8'd128);
    send_command(make_cmd(CMD_ALLOC, 8'd9, 8'd128, 7'd0));
    send_command(make_cmd(CMD_WRITE, 8'd9, 8'd0, 7'd127));
    send_command(make_cmd(CMD_READ, 8'd9, 8'd0, 7'd127));
    send_command(make_cmd(CMD_ALLOC, 8'd9, 8'd1, 7'd0));

    // Random part in short phases; each phase starts with a fresh frame
    // count, which also empties the page table, and a new idle pattern.
    for (int ph = 0; ph < 28; ph++) begin
      write_frame_count(ph < settings.size() ? settings[ph] : 8'($urandom_range(1, 128)));
      sender_idle_pct    = idle_mode[ph % 4][0];
      receiver_stall_pct = idle_mode[ph % 4][1];
      for (int k = 0; k < 50; k++) begin
        if (ph == 5 && k == 25) wait_drained();
        send_command(random_command());
      end
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
